// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the cursor overlay RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define COV_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cursor overlay assertion failed");
`define COV_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cursor overlay assertion failed");
`else
`define COV_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define COV_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/cov_pkg.sv
// Types, constants and helpers for the cursor overlay block.
package cov_pkg;

  localparam int CURSOR_SIZE = 16;
  localparam int COORD_BITS = 13;
  localparam int ROW_BITS = $clog2(CURSOR_SIZE);
  localparam int POS_BITS = COORD_BITS + 5;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 12;

  localparam logic [7:0] HIDE_MAX = 8'hff;
  localparam logic [11:0] CLIP_MAX_X_RST = 12'd640;
  localparam logic [11:0] CLIP_MAX_Y_RST = 12'd480;

  typedef enum logic [2:0] {
    OP_PIXEL   = 3'd0,
    OP_LOAD    = 3'd1,
    OP_MOVE    = 3'd2,
    OP_HIDE    = 3'd3,
    OP_UNHIDE  = 3'd4,
    OP_ENABLE  = 3'd5,
    OP_DISABLE = 3'd6,
    OP_DAMAGE  = 3'd7
  } op_e;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_LOG_DEPTH  = 3'd0,
    CFG_BIT_SWAP   = 3'd1,
    CFG_CLIP_MIN_X = 3'd2,
    CFG_CLIP_MIN_Y = 3'd3,
    CFG_CLIP_MAX_X = 3'd4,
    CFG_CLIP_MAX_Y = 3'd5,
    CFG_HOT_X      = 3'd6,
    CFG_HOT_Y      = 3'd7
  } cfg_reg_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [POS_BITS-1:0] pos_t;
  typedef logic signed [5:0] hot_t;
  typedef logic [CURSOR_SIZE-1:0] plane_row_t;
  typedef logic [ROW_BITS-1:0] row_idx_t;

  typedef struct packed {
    logic [1:0]  log_depth;
    logic        bit_swap;
    logic [11:0] clip_min_x;
    logic [11:0] clip_min_y;
    logic [11:0] clip_max_x;
    logic [11:0] clip_max_y;
    hot_t        hot_x;
    hot_t        hot_y;
  } cfg_t;

  typedef struct packed {
    op_e         op;
    coord_t      coord_x;
    coord_t      coord_y;
    coord_t      coord_x2;
    coord_t      coord_y2;
    logic [7:0]  fb_byte;
    logic [15:0] clear_bits;
    logic [15:0] set_bits;
    logic [3:0]  cursor_row;
  } req_t;

  typedef struct packed {
    coord_t     cursor_x;
    coord_t     cursor_y;
    logic [7:0] hide_count;
    logic       enabled;
  } cur_state_t;

  function automatic pos_t origin(coord_t c, hot_t hot);
    return pos_t'(c) - pos_t'(hot);
  endfunction

  function automatic logic [7:0] data_tab(logic [1:0] n);
    logic [7:0] d;
    unique case (n)
      2'd0: d = 8'h00;
      2'd1: d = 8'hff;
      2'd2: d = 8'h00;
      2'd3: d = 8'hff;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] mask_tab(logic [1:0] n);
    logic [7:0] m;
    unique case (n)
      2'd0: m = 8'hff;
      2'd1: m = 8'h00;
      2'd2: m = 8'h00;
      2'd3: m = 8'hff;
    endcase
    return m;
  endfunction

endpackage

// File: hw/rtl/cov_if.sv
// Request and result channel interfaces of the cursor overlay block.
interface cov_in_if;
  logic                valid;
  logic                ready;
  logic [2:0]          op;
  cov_pkg::coord_t     coord_x;
  cov_pkg::coord_t     coord_y;
  cov_pkg::coord_t     coord_x2;
  cov_pkg::coord_t     coord_y2;
  logic [7:0]          fb_byte;
  logic [15:0]         clear_bits;
  logic [15:0]         set_bits;
  logic [3:0]          cursor_row;

  modport source (
    output valid, op, coord_x, coord_y, coord_x2, coord_y2, fb_byte,
    output clear_bits, set_bits, cursor_row,
    input  ready
  );
  modport sink (
    input  valid, op, coord_x, coord_y, coord_x2, coord_y2, fb_byte,
    input  clear_bits, set_bits, cursor_row,
    output ready
  );
endinterface

interface cov_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       shown;

  modport source (output valid, out_byte, shown, input ready);
  modport sink (input valid, out_byte, shown, output ready);
endinterface

// File: hw/rtl/cursor_overlay_mask_xor_core.sv
// Cursor overlay top level: configuration, request and result registers.
// A request is held in the request register, and its result in the result register.
// Throughput: one request per cycle while results are taken; the result register frees while its result is taken.
// Set by one combinational pass from the request register through state and planes.
// Reset (rst, synchronous, high) clears cursor state and loads default configuration.
// Cursor planes hold undefined rows until loaded.
`include "assert_macros.svh"

module cursor_overlay_mask_xor_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [cov_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [cov_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  cov_in_if.sink                               item,
  cov_out_if.source                            result
);

  cov_pkg::cfg_t       cfg;
  cov_pkg::req_t       req;
  logic                req_valid;
  logic                advance;
  logic                fire;
  cov_pkg::cur_state_t st;
  cov_pkg::row_idx_t   rd_row;
  cov_pkg::plane_row_t clear_row;
  cov_pkg::plane_row_t set_row;
  logic                shown_next;
  logic [7:0]          byte_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.log_depth <= 2'd0;
      cfg.bit_swap <= 1'b0;
      cfg.clip_min_x <= 12'd0;
      cfg.clip_min_y <= 12'd0;
      cfg.clip_max_x <= cov_pkg::CLIP_MAX_X_RST;
      cfg.clip_max_y <= cov_pkg::CLIP_MAX_Y_RST;
      cfg.hot_x <= '0;
      cfg.hot_y <= '0;
    end else if (cfg_we) begin
      unique case (cov_pkg::cfg_reg_e'(cfg_index))
        cov_pkg::CFG_LOG_DEPTH:  cfg.log_depth <= cfg_data[1:0];
        cov_pkg::CFG_BIT_SWAP:   cfg.bit_swap <= cfg_data[0];
        cov_pkg::CFG_CLIP_MIN_X: cfg.clip_min_x <= cfg_data[11:0];
        cov_pkg::CFG_CLIP_MIN_Y: cfg.clip_min_y <= cfg_data[11:0];
        cov_pkg::CFG_CLIP_MAX_X: cfg.clip_max_x <= cfg_data[11:0];
        cov_pkg::CFG_CLIP_MAX_Y: cfg.clip_max_y <= cfg_data[11:0];
        cov_pkg::CFG_HOT_X:      cfg.hot_x <= cov_pkg::hot_t'(cfg_data[5:0]);
        cov_pkg::CFG_HOT_Y:      cfg.hot_y <= cov_pkg::hot_t'(cfg_data[5:0]);
      endcase
    end
  end

  assign advance = !result.valid || result.ready;
  assign fire = req_valid && advance;
  assign item.ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (item.ready) begin
      req_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      req.op <= cov_pkg::op_e'(item.op);
      req.coord_x <= item.coord_x;
      req.coord_y <= item.coord_y;
      req.coord_x2 <= item.coord_x2;
      req.coord_y2 <= item.coord_y2;
      req.fb_byte <= item.fb_byte;
      req.clear_bits <= item.clear_bits;
      req.set_bits <= item.set_bits;
      req.cursor_row <= item.cursor_row;
    end
  end

  cov_state u_state (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .req        (req),
    .cfg        (cfg),
    .rd_row     (rd_row),
    .clear_row  (clear_row),
    .set_row    (set_row),
    .st         (st),
    .shown_next (shown_next)
  );

  cov_overlay u_overlay (
    .req       (req),
    .cfg       (cfg),
    .st        (st),
    .clear_row (clear_row),
    .set_row   (set_row),
    .rd_row    (rd_row),
    .out_byte  (byte_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.out_byte <= byte_next;
      result.shown <= shown_next;
    end
  end

  `COV_ASSERT_NXT(a_ctrl_zero, clk, rst, fire && req.op != cov_pkg::OP_PIXEL, result.out_byte == 8'h00)
  `COV_ASSERT_NXT(a_shown_state, clk, rst, fire, result.shown == (st.enabled && st.hide_count == 8'h00))
  `COV_ASSERT_NXT(a_hidden_pass, clk, rst, fire && req.op == cov_pkg::OP_PIXEL && !(st.enabled && st.hide_count == 8'h00), result.out_byte == $past(req.fb_byte))
  `COV_ASSERT_IMP(a_stall_block, clk, rst, result.valid && !result.ready && req_valid, !item.ready)

endmodule

// File: hw/rtl/cov_state.sv
// Cursor state and row planes, updated by control requests.
module cov_state (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  cov_pkg::req_t       req,
  input  cov_pkg::cfg_t       cfg,
  input  cov_pkg::row_idx_t   rd_row,
  output cov_pkg::plane_row_t clear_row,
  output cov_pkg::plane_row_t set_row,
  output cov_pkg::cur_state_t st,
  output logic                shown_next
);

  cov_pkg::plane_row_t clear_plane [cov_pkg::CURSOR_SIZE];
  cov_pkg::plane_row_t set_plane [cov_pkg::CURSOR_SIZE];
  cov_pkg::cur_state_t st_next;
  cov_pkg::pos_t       x0;
  cov_pkg::pos_t       y0;
  logic                overlap;
  logic [7:0]          hide_inc;
  logic                load_ok;

  assign load_ok = int'(req.cursor_row) < cov_pkg::CURSOR_SIZE;

  always_comb begin
    x0 = cov_pkg::origin(st.cursor_x, cfg.hot_x);
    y0 = cov_pkg::origin(st.cursor_y, cfg.hot_y);
    overlap = (x0 < cov_pkg::pos_t'(req.coord_x2))
      && (cov_pkg::pos_t'(req.coord_x) < x0 + cov_pkg::pos_t'(cov_pkg::CURSOR_SIZE))
      && (y0 < cov_pkg::pos_t'(req.coord_y2))
      && (cov_pkg::pos_t'(req.coord_y) < y0 + cov_pkg::pos_t'(cov_pkg::CURSOR_SIZE));
    hide_inc = (st.hide_count == cov_pkg::HIDE_MAX) ? st.hide_count
                                                    : st.hide_count + 8'd1;
    st_next = st;
    unique case (req.op)
      cov_pkg::OP_PIXEL: begin
      end
      cov_pkg::OP_LOAD: begin
      end
      cov_pkg::OP_MOVE: begin
        st_next.cursor_x = req.coord_x;
        st_next.cursor_y = req.coord_y;
      end
      cov_pkg::OP_HIDE: begin
        st_next.hide_count = hide_inc;
      end
      cov_pkg::OP_UNHIDE: begin
        if (st.hide_count != 8'd0) begin
          st_next.hide_count = st.hide_count - 8'd1;
        end
      end
      cov_pkg::OP_ENABLE: begin
        st_next.enabled = 1'b1;
      end
      cov_pkg::OP_DISABLE: begin
        st_next.enabled = 1'b0;
      end
      cov_pkg::OP_DAMAGE: begin
        st_next.hide_count = overlap ? hide_inc : 8'd0;
      end
    endcase
  end

  assign shown_next = st_next.enabled && (st_next.hide_count == 8'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && req.op == cov_pkg::OP_LOAD && load_ok) begin
      clear_plane[cov_pkg::row_idx_t'(req.cursor_row)] <= cov_pkg::plane_row_t'(req.clear_bits);
      set_plane[cov_pkg::row_idx_t'(req.cursor_row)] <= cov_pkg::plane_row_t'(req.set_bits);
    end
  end

  assign clear_row = clear_plane[rd_row];
  assign set_row = set_plane[rd_row];

endmodule

// File: hw/rtl/cov_overlay.sv
// Per-pixel AND/XOR overlay of one framebuffer byte.
module cov_overlay (
  input  cov_pkg::req_t       req,
  input  cov_pkg::cfg_t       cfg,
  input  cov_pkg::cur_state_t st,
  input  cov_pkg::plane_row_t clear_row,
  input  cov_pkg::plane_row_t set_row,
  output cov_pkg::row_idx_t   rd_row,
  output logic [7:0]          out_byte
);

  cov_pkg::pos_t     xp;
  cov_pkg::pos_t     yp;
  cov_pkg::pos_t     by;
  cov_pkg::pos_t     rel_y;
  cov_pkg::pos_t     bx_base;
  logic              row_hit;
  logic              shown;
  logic [3:0]        bits;
  logic [3:0]        ppb;
  logic [7:0]        pmask;
  logic [2:0]        bswp;
  cov_pkg::pos_t     px [8];
  cov_pkg::pos_t     rel_x [8];
  logic              hit [8];
  cov_pkg::row_idx_t sh [8];
  logic [1:0]        n [8];
  logic [2:0]        s [8];
  logic [7:0]        mbyte;
  logic [7:0]        dbyte;

  always_comb begin
    xp = cov_pkg::origin(st.cursor_x, cfg.hot_x);
    yp = cov_pkg::origin(st.cursor_y, cfg.hot_y);
    by = cov_pkg::pos_t'(req.coord_y);
    rel_y = by - yp;
    rd_row = cov_pkg::row_idx_t'(rel_y);
    row_hit = (by >= yp) && (by < yp + cov_pkg::pos_t'(cov_pkg::CURSOR_SIZE))
      && (by >= cov_pkg::pos_t'(cfg.clip_min_y))
      && (by < cov_pkg::pos_t'(cfg.clip_max_y));
    shown = st.enabled && (st.hide_count == 8'd0);
    bits = 4'd1 << cfg.log_depth;
    ppb = 4'd8 >> cfg.log_depth;
    pmask = 8'((9'd1 << bits) - 9'd1);
    bswp = cfg.bit_swap ? 3'(4'd8 - bits) : 3'd0;
    bx_base = cov_pkg::pos_t'(req.coord_x) <<< (2'd3 - cfg.log_depth);
    mbyte = 8'hff;
    dbyte = 8'h00;
    for (int i = 0; i < 8; i++) begin
      px[i] = bx_base + cov_pkg::pos_t'(i);
      rel_x[i] = px[i] - xp;
      hit[i] = (4'(i) < ppb) && (px[i] >= xp)
        && (px[i] < xp + cov_pkg::pos_t'(cov_pkg::CURSOR_SIZE))
        && (px[i] >= cov_pkg::pos_t'(cfg.clip_min_x))
        && (px[i] < cov_pkg::pos_t'(cfg.clip_max_x));
      sh[i] = cov_pkg::row_idx_t'(cov_pkg::CURSOR_SIZE - 1) - cov_pkg::row_idx_t'(rel_x[i]);
      n[i] = {clear_row[sh[i]], set_row[sh[i]]};
      s[i] = 3'(4'(i) << cfg.log_depth) ^ bswp;
      if (hit[i]) begin
        mbyte = mbyte & ~(pmask << s[i]);
        mbyte = mbyte | ((cov_pkg::mask_tab(n[i]) & pmask) << s[i]);
        dbyte = dbyte | ((cov_pkg::data_tab(n[i]) & pmask) << s[i]);
      end
    end
    if (req.op != cov_pkg::OP_PIXEL) begin
      out_byte = 8'h00;
    end else if (shown && row_hit) begin
      out_byte = (req.fb_byte & mbyte) ^ dbyte;
    end else begin
      out_byte = req.fb_byte;
    end
  end

endmodule

// File: tb/sv/cursor_overlay_checker.sv
// Checker for the cursor overlay: predicts each result and compares it.
module cursor_overlay_checker
  import cov_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  cov_in_if                         item,
  cov_out_if                        result,
  output int                        errors,
  output int                        in_flight,
  output int                        checked
);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       shown;
  } overlay_out_t;

  overlay_out_t due_outputs[$];

  plane_row_t clear_rows[CURSOR_SIZE];
  plane_row_t set_rows[CURSOR_SIZE];
  coord_t     cur_x;
  coord_t     cur_y;
  logic [7:0] hide_cnt;
  logic       enabled;

  int   depth_log;
  logic swap;
  int   clip_x0, clip_y0, clip_x1, clip_y1;
  int   hot_dx, hot_dy;

  int err_n;
  int chk_n;

  function automatic logic [7:0] overlay_byte(logic [7:0] fb, int bx, int by);
    int         bits, ppb, swap_sh, xp, yp, px, col, lane;
    logic [7:0] pmask, and_m, xor_m;
    logic [1:0] pair;
    logic [3:0] crow;
    bits    = 1 << depth_log;
    ppb     = 8 >> depth_log;
    pmask   = 8'((1 << bits) - 1);
    swap_sh = swap ? 8 - bits : 0;
    xp      = int'(cur_x) - hot_dx;
    yp      = int'(cur_y) - hot_dy;
    and_m   = 8'hff;
    xor_m   = 8'h00;
    if (by < yp || by >= yp + CURSOR_SIZE || by < clip_y0 || by >= clip_y1) return fb;
    crow = 4'(by - yp);
    for (int i = 0; i < ppb; i++) begin
      px = bx * ppb + i;
      if (px < xp || px >= xp + CURSOR_SIZE || px < clip_x0 || px >= clip_x1) continue;
      col   = px - xp;
      pair  = {clear_rows[crow][CURSOR_SIZE-1-col], set_rows[crow][CURSOR_SIZE-1-col]};
      lane  = (i * bits) ^ swap_sh;
      and_m &= ~(pmask << lane);
      if (pair == 2'b00 || pair == 2'b11) and_m |= pmask << lane;
      if (pair[0]) xor_m |= pmask << lane;
    end
    return (fb & and_m) ^ xor_m;
  endfunction

  function automatic overlay_out_t next_overlay_out(req_t rq);
    overlay_out_t o;
    int           x0, y0;
    o.out_byte = 8'h00;
    x0 = int'(cur_x) - hot_dx;
    y0 = int'(cur_y) - hot_dy;
    case (rq.op)
      OP_PIXEL: begin
        if (enabled && hide_cnt == 8'd0)
          o.out_byte = overlay_byte(rq.fb_byte, int'(rq.coord_x), int'(rq.coord_y));
        else
          o.out_byte = rq.fb_byte;
      end
      OP_LOAD: begin
        clear_rows[rq.cursor_row] = rq.clear_bits;
        set_rows[rq.cursor_row]   = rq.set_bits;
      end
      OP_MOVE: begin
        cur_x = rq.coord_x;
        cur_y = rq.coord_y;
      end
      OP_HIDE: begin
        if (hide_cnt != HIDE_MAX) hide_cnt++;
      end
      OP_UNHIDE: begin
        if (hide_cnt != 8'd0) hide_cnt--;
      end
      OP_ENABLE: enabled = 1'b1;
      OP_DISABLE: enabled = 1'b0;
      OP_DAMAGE: begin
        if (x0 < int'(rq.coord_x2) && int'(rq.coord_x) < x0 + CURSOR_SIZE &&
            y0 < int'(rq.coord_y2) && int'(rq.coord_y) < y0 + CURSOR_SIZE) begin
          if (hide_cnt != HIDE_MAX) hide_cnt++;
        end else begin
          hide_cnt = 8'd0;
        end
      end
      default: ;
    endcase
    o.shown = enabled && hide_cnt == 8'd0;
    return o;
  endfunction

  always @(posedge clk) begin
    overlay_out_t want;
    req_t         rq;
    hot_t         h;
    if (rst) begin
      cur_x     = '0;
      cur_y     = '0;
      hide_cnt  = 8'd0;
      enabled   = 1'b0;
      depth_log = 0;
      swap      = 1'b0;
      clip_x0   = 0;
      clip_y0   = 0;
      clip_x1   = int'(CLIP_MAX_X_RST);
      clip_y1   = int'(CLIP_MAX_Y_RST);
      hot_dx    = 0;
      hot_dy    = 0;
      err_n     = 0;
      chk_n     = 0;
      due_outputs.delete();
      in_flight <= 0;
      errors    <= 0;
      checked   <= 0;
    end else begin
      if (result.valid && result.ready) begin
        if (due_outputs.size() == 0) begin
          err_n++;
          $display("%0t: result %02h/%0b with no request outstanding",
                   $time, result.out_byte, result.shown);
        end else begin
          want = due_outputs.pop_front();
          chk_n++;
          if (result.out_byte !== want.out_byte) begin
            err_n++;
            $display("%0t: out_byte expected %02h, got %02h",
                     $time, want.out_byte, result.out_byte);
          end
          if (result.shown !== want.shown) begin
            err_n++;
            $display("%0t: shown expected %0b, got %0b", $time, want.shown, result.shown);
          end
        end
      end
      if (cfg_we) begin
        h = cfg_data[5:0];
        case (cfg_reg_e'(cfg_index))
          CFG_LOG_DEPTH:  depth_log = int'(cfg_data[1:0]);
          CFG_BIT_SWAP:   swap = cfg_data[0];
          CFG_CLIP_MIN_X: clip_x0 = int'(cfg_data);
          CFG_CLIP_MIN_Y: clip_y0 = int'(cfg_data);
          CFG_CLIP_MAX_X: clip_x1 = int'(cfg_data);
          CFG_CLIP_MAX_Y: clip_y1 = int'(cfg_data);
          CFG_HOT_X:      hot_dx = int'(h);
          CFG_HOT_Y:      hot_dy = int'(h);
          default: ;
        endcase
      end
      if (item.valid && item.ready) begin
        rq.op         = op_e'(item.op);
        rq.coord_x    = item.coord_x;
        rq.coord_y    = item.coord_y;
        rq.coord_x2   = item.coord_x2;
        rq.coord_y2   = item.coord_y2;
        rq.fb_byte    = item.fb_byte;
        rq.clear_bits = item.clear_bits;
        rq.set_bits   = item.set_bits;
        rq.cursor_row = item.cursor_row;
        due_outputs.push_back(next_overlay_out(rq));
      end
      in_flight <= due_outputs.size();
      errors    <= err_n;
      checked   <= chk_n;
    end
  end

endmodule

// File: tb/sv/tb.sv
// Testbench top for the cursor overlay: stimulus, idling, pressure and verdict.
module tb;
  import cov_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 175;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  cov_in_if  item_if ();
  cov_out_if res_if ();

  int   fail_count;
  int   in_flight;
  int   checked;
  int   sent;
  int   idle_pct;
  int   stall_pct;
  bit   hold_off_req;
  cfg_t screen;

  cursor_overlay_mask_xor_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_if),
    .result    (res_if)
  );

  cursor_overlay_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_if),
    .result    (res_if),
    .errors    (fail_count),
    .in_flight (in_flight),
    .checked   (checked)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("tb failed");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        res_if.ready <= (int'($urandom_range(99)) >= stall_pct);
      end
    end
  end

  function automatic coord_t fit(int v);
    if (v < -4096) v = -4096;
    else if (v > 4095) v = 4095;
    return coord_t'(v);
  endfunction

  function automatic req_t base_req(op_e op);
    req_t r;
    r.op         = op;
    r.coord_x    = coord_t'($urandom);
    r.coord_y    = coord_t'($urandom);
    r.coord_x2   = coord_t'($urandom);
    r.coord_y2   = coord_t'($urandom);
    r.fb_byte    = 8'($urandom);
    r.clear_bits = 16'($urandom);
    r.set_bits   = 16'($urandom);
    r.cursor_row = 4'($urandom);
    return r;
  endfunction

  function automatic int pick_spot(int lo, int hi);
    case ($urandom_range(2))
      0: return lo - 20 + int'($urandom_range(60));
      1: return hi - 30 + int'($urandom_range(40));
      default: return int'($urandom_range(704)) - 64;
    endcase
  endfunction

  function automatic cfg_t screen_for(int p);
    cfg_t c;
    c.log_depth  = 2'(p);
    c.bit_swap   = 1'(p >> 2);
    c.clip_min_x = 12'($urandom_range(300));
    c.clip_min_y = 12'($urandom_range(300));
    c.clip_max_x = c.clip_min_x + 12'($urandom_range(1, 700));
    c.clip_max_y = c.clip_min_y + 12'($urandom_range(1, 700));
    c.hot_x      = hot_t'(int'($urandom_range(32)) - 16);
    c.hot_y      = hot_t'(int'($urandom_range(32)) - 16);
    case (p)
      0: begin
        c.clip_min_x = 12'd0;
        c.clip_min_y = 12'd0;
        c.clip_max_x = CLIP_MAX_X_RST;
        c.clip_max_y = CLIP_MAX_Y_RST;
        c.hot_x      = 6'sd0;
        c.hot_y      = 6'sd0;
      end
      1: begin
        c.clip_min_x = 12'd0;
        c.clip_min_y = 12'd0;
        c.clip_max_x = 12'd4095;
        c.clip_max_y = 12'd4095;
        c.hot_x      = -6'sd16;
        c.hot_y      = -6'sd16;
      end
      2: begin
        c.clip_min_x = 12'd100;
        c.clip_min_y = 12'd80;
        c.clip_max_x = 12'd50;
        c.clip_max_y = 12'd40;
        c.hot_x      = 6'sd16;
        c.hot_y      = 6'sd16;
      end
      3: begin
        c.clip_min_x = 12'd4095;
        c.clip_min_y = 12'd4095;
        c.clip_max_x = 12'd4095;
        c.clip_max_y = 12'd4095;
      end
      6: begin
        c.clip_min_x = 12'd4000;
        c.clip_min_y = 12'd4000;
        c.clip_max_x = 12'd4095;
        c.clip_max_y = 12'd4095;
        c.hot_x      = -6'sd16;
        c.hot_y      = 6'sd16;
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic put_reg(cfg_reg_e idx, logic [CFG_DATA_BITS-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  task automatic write_screen(cfg_t c);
    screen = c;
    put_reg(CFG_LOG_DEPTH, 12'(c.log_depth));
    put_reg(CFG_BIT_SWAP, 12'(c.bit_swap));
    put_reg(CFG_CLIP_MIN_X, c.clip_min_x);
    put_reg(CFG_CLIP_MIN_Y, c.clip_min_y);
    put_reg(CFG_CLIP_MAX_X, c.clip_max_x);
    put_reg(CFG_CLIP_MAX_Y, c.clip_max_y);
    put_reg(CFG_HOT_X, {6'd0, c.hot_x});
    put_reg(CFG_HOT_Y, {6'd0, c.hot_y});
    cfg_we <= 1'b0;
  endtask

  // Hold valid across back-to-back requests; drop it only for a gap.
  task automatic send_req(req_t r);
    while (int'($urandom_range(99)) < idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk);
    end
    item_if.valid      <= 1'b1;
    item_if.op         <= r.op;
    item_if.coord_x    <= r.coord_x;
    item_if.coord_y    <= r.coord_y;
    item_if.coord_x2   <= r.coord_x2;
    item_if.coord_y2   <= r.coord_y2;
    item_if.fb_byte    <= r.fb_byte;
    item_if.clear_bits <= r.clear_bits;
    item_if.set_bits   <= r.set_bits;
    item_if.cursor_row <= r.cursor_row;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_ctl(op_e op);
    send_req(base_req(op));
  endtask

  task automatic send_pixel(int bx, int by, logic [7:0] fb);
    req_t r;
    r         = base_req(OP_PIXEL);
    r.coord_x = fit(bx);
    r.coord_y = fit(by);
    r.fb_byte = fb;
    send_req(r);
  endtask

  task automatic send_move(int x, int y);
    req_t r;
    r         = base_req(OP_MOVE);
    r.coord_x = fit(x);
    r.coord_y = fit(y);
    send_req(r);
  endtask

  task automatic send_damage(int x, int y, int x2, int y2);
    req_t r;
    r          = base_req(OP_DAMAGE);
    r.coord_x  = fit(x);
    r.coord_y  = fit(y);
    r.coord_x2 = fit(x2);
    r.coord_y2 = fit(y2);
    send_req(r);
  endtask

  task automatic send_load(logic [3:0] row, logic [15:0] clr, logic [15:0] st);
    req_t r;
    r            = base_req(OP_LOAD);
    r.cursor_row = row;
    r.clear_bits = clr;
    r.set_bits   = st;
    send_req(r);
  endtask

  task automatic wait_idle();
    item_if.valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Place the cursor near the screen and scan bytes around it.
  task automatic draw_pass();
    int cx, cy, xp, yp, px, py, shift;
    shift = 3 - int'(screen.log_depth);
    repeat ($urandom_range(2)) send_load(4'($urandom), 16'($urandom), 16'($urandom));
    cx = int'(fit(pick_spot(int'(screen.clip_min_x), int'(screen.clip_max_x))));
    cy = int'(fit(pick_spot(int'(screen.clip_min_y), int'(screen.clip_max_y))));
    xp = cx - int'(screen.hot_x);
    yp = cy - int'(screen.hot_y);
    send_move(cx, cy);
    send_ctl(OP_ENABLE);
    send_damage(4095, 4095, -4096, -4096);
    repeat (24) begin
      px = xp - 4 + int'($urandom_range(23));
      py = yp - 2 + int'($urandom_range(19));
      case ($urandom_range(19))
        0: send_ctl(OP_HIDE);
        1: send_ctl(OP_UNHIDE);
        default: ;
      endcase
      send_pixel(px >>> shift, py, 8'($urandom));
    end
    send_damage(xp + int'($urandom_range(15)), yp + int'($urandom_range(15)),
                xp + 20, yp + 20);
    send_pixel(xp >>> shift, yp, 8'($urandom));
    send_ctl(OP_UNHIDE);
    if ($urandom_range(2) == 0) send_ctl(OP_DISABLE);
  endtask

  task automatic noise_burst();
    repeat (8) send_req(base_req(op_e'($urandom_range(7))));
  endtask

  task automatic hide_burst();
    send_ctl(OP_ENABLE);
    repeat (int'(HIDE_MAX) + 3) send_ctl(OP_HIDE);
    send_pixel(int'($urandom_range(40)), int'($urandom_range(40)), 8'($urandom));
    repeat (2) send_ctl(OP_UNHIDE);
    send_damage(4095, 4095, -4096, -4096);
  endtask

  initial begin
    int phase_start;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    item_if.valid <= 1'b0;
    item_if.op    <= OP_PIXEL;
    item_if.coord_x    <= '0;
    item_if.coord_y    <= '0;
    item_if.coord_x2   <= '0;
    item_if.coord_y2   <= '0;
    item_if.fb_byte    <= '0;
    item_if.clear_bits <= '0;
    item_if.set_bits   <= '0;
    item_if.cursor_row <= '0;
    sent         = 0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_off_req = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_load(4'd0, 16'h0000, 16'h0000);
    send_load(4'd1, 16'hffff, 16'hffff);
    send_load(4'd2, 16'hffff, 16'h0000);
    send_load(4'd3, 16'h00ff, 16'h0f0f);
    send_pixel(0, 0, 8'ha5);
    send_ctl(OP_ENABLE);
    send_move(-4096, -4096);
    send_pixel(-4096, -4096, 8'hff);
    send_move(4095, 4095);
    send_pixel(4095, 4095, 8'h00);
    send_move(8, 4);
    send_pixel(1, 4, 8'h00);
    send_pixel(1, 5, 8'hff);
    send_pixel(2, 7, 8'h5a);
    send_pixel(0, 7, 8'h3c);
    send_ctl(OP_HIDE);
    send_pixel(1, 6, 8'hc3);
    send_ctl(OP_HIDE);
    repeat (3) send_ctl(OP_UNHIDE);
    send_pixel(1, 6, 8'hc3);
    send_damage(0, 0, 100, 100);
    send_pixel(2, 6, 8'h81);
    send_damage(200, 200, 300, 300);
    send_damage(100, 100, 0, 0);
    send_ctl(OP_DISABLE);
    send_pixel(1, 4, 8'h00);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_screen(screen_for(p));
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 52; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 52; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      phase_start = sent;
      if (p == 0) begin
        for (int r = 4; r < CURSOR_SIZE; r++)
          send_load(4'(r), 16'($urandom), 16'($urandom));
      end
      if (p == 4) hold_off_req = 1'b1;
      if (p == 2 || p == 7) hide_burst();
      while (sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(99) < 65) draw_pass();
        else noise_burst();
      end
    end

    wait_idle();
    $display("Summary: %0d requests over %0d screen settings (every depth, both bit orders,",
             sent, PHASES);
    $display("  empty and full clips, hotspot extremes); %0d results compared", checked);
    if (fail_count == 0 && in_flight == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
